// ===== src/rcf_pkg.sv =====
// Shared types, constants and the microcode table of the chunk-stream framer.
// Used by rcf_sequencer, rcf_datapath and rtmp_chunk_framer.
package rcf_pkg;

  localparam logic [23:0] CHUNK_SIZE_RESET = 24'd128;

  localparam logic [1:0] FMT_FULL    = 2'd0;
  localparam logic [1:0] FMT_NO_SID  = 2'd1;
  localparam logic [1:0] FMT_TS_ONLY = 2'd2;
  localparam logic [1:0] FMT_CONT    = 2'd3;

  typedef logic [23:0] cfg_word_t;

  typedef struct packed {
    logic [1:0]  op;
    logic        first;
    logic [5:0]  chunk_stream_id;
    logic [7:0]  message_type;
    logic [31:0] message_stream_id;
    logic [23:0] timestamp;
    logic [23:0] message_length;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       message_end;
  } out_item_t;

  typedef logic [3:0] step_t;

  typedef enum logic [3:0] {
    SEL_BASIC,
    SEL_TS2,
    SEL_TS1,
    SEL_TS0,
    SEL_LEN2,
    SEL_LEN1,
    SEL_LEN0,
    SEL_TYPE,
    SEL_SID0,
    SEL_SID1,
    SEL_SID2,
    SEL_SID3,
    SEL_DATA,
    SEL_CONT
  } sel_t;

  typedef enum logic [1:0] {
    COND_NEXT,
    COND_FMT1,
    COND_FMT2,
    COND_ALWAYS
  } cond_t;

  typedef struct packed {
    sel_t  sel;
    cond_t cond;
    step_t target;
    logic  tail;
    logic  done;
  } ucode_t;

  localparam step_t STEP_HDR  = 4'd0;
  localparam step_t STEP_DATA = 4'd12;
  localparam step_t STEP_CONT = 4'd13;

  typedef struct packed {
    logic fmt1;
    logic fmt2;
    logic len_zero;
    logic msg_idle;
    logic chunk_full;
  } dp_status_t;

  typedef struct packed {
    logic emit;
    sel_t sel;
    logic item_end;
    logic hdr_end;
  } seq_ctrl_t;

  function automatic ucode_t ucode(input step_t step);
    ucode_t w;
    w = '{sel: SEL_DATA, cond: COND_NEXT, target: STEP_DATA, tail: 1'b0, done: 1'b1};
    unique case (step)
      4'd0:  w = '{SEL_BASIC, COND_NEXT,   STEP_DATA, 1'b0, 1'b0};
      4'd1:  w = '{SEL_TS2,   COND_NEXT,   STEP_DATA, 1'b0, 1'b0};
      4'd2:  w = '{SEL_TS1,   COND_NEXT,   STEP_DATA, 1'b0, 1'b0};
      4'd3:  w = '{SEL_TS0,   COND_FMT2,   STEP_DATA, 1'b1, 1'b0};
      4'd4:  w = '{SEL_LEN2,  COND_NEXT,   STEP_DATA, 1'b0, 1'b0};
      4'd5:  w = '{SEL_LEN1,  COND_NEXT,   STEP_DATA, 1'b0, 1'b0};
      4'd6:  w = '{SEL_LEN0,  COND_NEXT,   STEP_DATA, 1'b0, 1'b0};
      4'd7:  w = '{SEL_TYPE,  COND_FMT1,   STEP_DATA, 1'b1, 1'b0};
      4'd8:  w = '{SEL_SID0,  COND_NEXT,   STEP_DATA, 1'b0, 1'b0};
      4'd9:  w = '{SEL_SID1,  COND_NEXT,   STEP_DATA, 1'b0, 1'b0};
      4'd10: w = '{SEL_SID2,  COND_NEXT,   STEP_DATA, 1'b0, 1'b0};
      4'd11: w = '{SEL_SID3,  COND_ALWAYS, STEP_DATA, 1'b1, 1'b0};
      4'd12: w = '{SEL_DATA,  COND_NEXT,   STEP_DATA, 1'b0, 1'b1};
      4'd13: w = '{SEL_CONT,  COND_ALWAYS, STEP_DATA, 1'b0, 1'b0};
      default: w = '{SEL_DATA, COND_NEXT,  STEP_DATA, 1'b0, 1'b1};
    endcase
    return w;
  endfunction

endpackage

// ===== src/rcf_chan_if.sv =====
// Valid/ready channel carrying one payload of a chosen type per transfer.
// Payload types come from rcf_pkg.
interface rcf_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

// ===== src/rcf_sequencer.sv =====
// Step counter and microcode lookup that steer the framer datapath.
// Depends on rcf_pkg for the control word format and the program table.
module rcf_sequencer (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic                first,
  input  rcf_pkg::dp_status_t status,
  input  logic                out_free,
  output logic                busy,
  output rcf_pkg::seq_ctrl_t  ctrl
);

  rcf_pkg::step_t  step;
  rcf_pkg::ucode_t word;
  logic            taken;
  logic            hdr_fin;

  always_comb begin
    word = rcf_pkg::ucode(step);
    unique case (word.cond)
      rcf_pkg::COND_NEXT:   taken = 1'b0;
      rcf_pkg::COND_FMT1:   taken = status.fmt1;
      rcf_pkg::COND_FMT2:   taken = status.fmt2;
      rcf_pkg::COND_ALWAYS: taken = 1'b1;
      default:              taken = 1'b0;
    endcase
    hdr_fin       = taken && word.tail && status.len_zero;
    ctrl.emit     = busy && out_free;
    ctrl.sel      = word.sel;
    ctrl.item_end = word.done || hdr_fin;
    ctrl.hdr_end  = hdr_fin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= rcf_pkg::STEP_HDR;
    end else if (accept) begin
      if (first) begin
        busy <= 1'b1;
        step <= rcf_pkg::STEP_HDR;
      end else if (!status.msg_idle) begin
        busy <= 1'b1;
        step <= status.chunk_full ? rcf_pkg::STEP_CONT : rcf_pkg::STEP_DATA;
      end
    end else if (ctrl.emit) begin
      if (ctrl.item_end) begin
        busy <= 1'b0;
      end else if (taken) begin
        step <= word.target;
      end else begin
        step <= step + 4'd1;
      end
    end
  end

endmodule

// ===== src/rcf_datapath.sv =====
// Header fields, chunk counters, byte selection and the output register.
// Depends on rcf_pkg; driven by control words from rcf_sequencer.
module rcf_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  rcf_pkg::in_item_t   in_item,
  input  logic                cfg_we,
  input  rcf_pkg::cfg_word_t  cfg_data,
  input  rcf_pkg::seq_ctrl_t  ctrl,
  input  logic                out_ready,
  output rcf_pkg::dp_status_t status,
  output logic                out_free,
  output logic                out_valid,
  output rcf_pkg::out_item_t  out_item
);

  rcf_pkg::cfg_word_t chunk_size;
  rcf_pkg::in_item_t  held;
  logic [1:0]         fmt;
  logic [5:0]         held_stream_id;
  logic [23:0]        chunk_fill;
  logic [23:0]        bytes_left;
  logic [23:0]        limit;
  logic [7:0]         sel_byte;
  logic               is_data;

  always_comb begin
    limit             = (chunk_size == 24'd0) ? 24'd1 : chunk_size;
    status.fmt1       = (fmt == rcf_pkg::FMT_NO_SID);
    status.fmt2       = (fmt == rcf_pkg::FMT_TS_ONLY);
    status.len_zero   = (held.message_length == 24'd0);
    status.msg_idle   = (bytes_left == 24'd0);
    status.chunk_full = (chunk_fill >= limit);
    out_free          = !out_valid || out_ready;
    is_data           = (ctrl.sel == rcf_pkg::SEL_DATA);
  end

  always_comb begin
    unique case (ctrl.sel)
      rcf_pkg::SEL_BASIC: sel_byte = {fmt, held_stream_id};
      rcf_pkg::SEL_TS2:   sel_byte = held.timestamp[23:16];
      rcf_pkg::SEL_TS1:   sel_byte = held.timestamp[15:8];
      rcf_pkg::SEL_TS0:   sel_byte = held.timestamp[7:0];
      rcf_pkg::SEL_LEN2:  sel_byte = held.message_length[23:16];
      rcf_pkg::SEL_LEN1:  sel_byte = held.message_length[15:8];
      rcf_pkg::SEL_LEN0:  sel_byte = held.message_length[7:0];
      rcf_pkg::SEL_TYPE:  sel_byte = held.message_type;
      rcf_pkg::SEL_SID0:  sel_byte = held.message_stream_id[7:0];
      rcf_pkg::SEL_SID1:  sel_byte = held.message_stream_id[15:8];
      rcf_pkg::SEL_SID2:  sel_byte = held.message_stream_id[23:16];
      rcf_pkg::SEL_SID3:  sel_byte = held.message_stream_id[31:24];
      rcf_pkg::SEL_DATA:  sel_byte = held.data_byte;
      rcf_pkg::SEL_CONT:  sel_byte = {rcf_pkg::FMT_CONT, held_stream_id};
      default:            sel_byte = held.data_byte;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_size <= rcf_pkg::CHUNK_SIZE_RESET;
    end else if (cfg_we) begin
      chunk_size <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fmt            <= rcf_pkg::FMT_FULL;
      held_stream_id <= 6'd0;
      chunk_fill     <= 24'd0;
      bytes_left     <= 24'd0;
    end else if (accept && in_item.first) begin
      fmt            <= (in_item.op == rcf_pkg::FMT_CONT) ? rcf_pkg::FMT_TS_ONLY : in_item.op;
      held_stream_id <= in_item.chunk_stream_id;
      chunk_fill     <= 24'd0;
      bytes_left     <= in_item.message_length;
    end else if (ctrl.emit) begin
      if (is_data) begin
        chunk_fill <= chunk_fill + 24'd1;
        bytes_left <= bytes_left - 24'd1;
      end else if (ctrl.sel == rcf_pkg::SEL_CONT) begin
        chunk_fill <= 24'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      out_item.out_byte    <= sel_byte;
      out_item.run_last    <= ctrl.item_end;
      out_item.message_end <= ctrl.hdr_end || (is_data && bytes_left == 24'd1);
    end
  end

endmodule

// ===== src/rtmp_chunk_framer.sv =====
// Chunk-stream framer: one result byte per cycle while an item is in progress
// and the output is free. An item is taken only when the sequencer is idle; it
// yields 0 to 13 bytes through the output register, and the next item is taken
// only once the last byte of the current one has been emitted.
// Synchronous active-high reset clears counters, stream id and chunk size to 128.
module rtmp_chunk_framer (
  input  logic       clk,
  input  logic       rst,
  rcf_chan_if.sink   item,
  rcf_chan_if.source result,
  rcf_chan_if.sink   cfg
);

  logic                busy;
  logic                accept;
  logic                out_free;
  rcf_pkg::dp_status_t status;
  rcf_pkg::seq_ctrl_t  ctrl;

  assign item.ready = !busy;
  assign cfg.ready  = 1'b1;
  assign accept     = item.valid && !busy;

  rcf_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .first    (item.payload.first),
    .status   (status),
    .out_free (out_free),
    .busy     (busy),
    .ctrl     (ctrl)
  );

  rcf_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_item   (item.payload),
    .cfg_we    (cfg.valid),
    .cfg_data  (cfg.payload),
    .ctrl      (ctrl),
    .out_ready (result.ready),
    .status    (status),
    .out_free  (out_free),
    .out_valid (result.valid),
    .out_item  (result.payload)
  );

endmodule
